FILE: design/rar_pkg.sv
// Shared types and constants for the rational arithmetic reduction block.
// No dependencies.
package rar_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 2;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_DEN_ZERO = 2'd2
    } status_t;

endpackage

FILE: design/rar_front.sv
// Front end: accepts an item, checks it and forms the cross products.
// Depends on rar_pkg.
module rar_front
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [1:0]                 s_tuser,
    input  logic [OPERAND_WIDTH-1:0]   a_num,
    input  logic [OPERAND_WIDTH-1:0]   a_den,
    input  logic [OPERAND_WIDTH-1:0]   b_num,
    input  logic [OPERAND_WIDTH-1:0]   b_den,
    output logic                       push,
    output logic [4*OPERAND_WIDTH+1:0] push_data,
    input  logic                       full
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_PUSH
    } state_t;

    state_t         state_reg;
    op_t            op_reg;
    logic [W-1:0]   an_reg, ad_reg, bn_reg, bd_reg;
    logic [PW-1:0]  p0_reg, p1_reg, p2_reg;

    logic [W-1:0]   an_mag, ad_mag, bn_mag, bd_mag;
    logic [W-1:0]   mul_a, mul_b;
    logic [PW-1:0]  prod;
    logic           s0, s2, den_neg;
    logic           num_neg;
    logic [PW-1:0]  num_mag;
    status_t        status;

    assign an_mag = an_reg[W-1] ? (~an_reg + 1'b1) : an_reg;
    assign ad_mag = ad_reg[W-1] ? (~ad_reg + 1'b1) : ad_reg;
    assign bn_mag = bn_reg[W-1] ? (~bn_reg + 1'b1) : bn_reg;
    assign bd_mag = bd_reg[W-1] ? (~bd_reg + 1'b1) : bd_reg;

    always_comb begin
        mul_a = ad_mag;
        mul_b = bn_mag;
        case (state_reg)
            S_MUL0: begin
                mul_a = an_mag;
                mul_b = (op_reg == OP_MUL) ? bn_mag : bd_mag;
            end
            S_MUL1: begin
                mul_a = ad_mag;
                mul_b = (op_reg == OP_DIV) ? bn_mag : bd_mag;
            end
            default: begin
                mul_a = ad_mag;
                mul_b = bn_mag;
            end
        endcase
    end

    assign prod = PW'(mul_a) * PW'(mul_b);

    assign s0      = an_reg[W-1] ^ ((op_reg == OP_MUL) ? bn_reg[W-1] : bd_reg[W-1]);
    assign s2      = ad_reg[W-1] ^ bn_reg[W-1] ^ (op_reg == OP_SUB);
    assign den_neg = ad_reg[W-1] ^ ((op_reg == OP_DIV) ? bn_reg[W-1] : bd_reg[W-1]);

    always_comb begin
        num_neg = s0;
        num_mag = p0_reg;
        if (op_reg == OP_ADD || op_reg == OP_SUB) begin
            if (s0 == s2) begin
                num_mag = p0_reg + p2_reg;
            end else if (p0_reg >= p2_reg) begin
                num_mag = p0_reg - p2_reg;
            end else begin
                num_neg = s2;
                num_mag = p2_reg - p0_reg;
            end
        end
    end

    always_comb begin
        if (ad_reg == '0 || bd_reg == '0) begin
            status = ST_DEN_ZERO;
        end else if (op_reg == OP_DIV && bn_reg == '0) begin
            status = ST_DIV_ZERO;
        end else begin
            status = ST_OK;
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign push      = (state_reg == S_PUSH) && !full;
    assign push_data = {status, num_neg ^ den_neg, num_mag, p1_reg[PW-2:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= op_t'(s_tuser);
                        an_reg    <= a_num;
                        ad_reg    <= a_den;
                        bn_reg    <= b_num;
                        bd_reg    <= b_den;
                        state_reg <= S_MUL0;
                    end
                end
                S_MUL0: begin
                    p0_reg    <= prod;
                    state_reg <= S_MUL1;
                end
                S_MUL1: begin
                    p1_reg    <= prod;
                    state_reg <= (op_reg == OP_ADD || op_reg == OP_SUB) ? S_MUL2 : S_PUSH;
                end
                S_MUL2: begin
                    p2_reg    <= prod;
                    state_reg <= S_PUSH;
                end
                S_PUSH: begin
                    if (!full) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: design/rar_queue.sv
// Short register queue between the front end and the reduction back end.
// Depends on rar_pkg.
module rar_queue
    import rar_pkg::*;
#(
    parameter int DATA_WIDTH = 4 * OPERAND_WIDTH_DEF + 2,
    parameter int DEPTH      = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  logic [DATA_WIDTH-1:0] push_data,
    output logic                  full,
    input  logic                  pop,
    output logic [DATA_WIDTH-1:0] pop_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = data_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("queue read while empty");
`endif

endmodule

FILE: design/rar_back.sv
// Back end: binary gcd, two serial divisions by the gcd, output register.
// Depends on rar_pkg.
module rar_back
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       empty,
    output logic                       pop,
    input  logic [4*OPERAND_WIDTH+1:0] pop_data,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [2*OPERAND_WIDTH:0]   res_num,
    output logic [2*OPERAND_WIDTH-2:0] res_den,
    output status_t                    status
);

    localparam int PW = 2 * OPERAND_WIDTH;
    localparam int QW = 2 * PW + 2;
    localparam int CW = $clog2(PW);

    typedef enum logic [1:0] {
        S_IDLE,
        S_GCD,
        S_DIV,
        S_OUT
    } state_t;

    state_t         state_reg;
    status_t        status_reg, q_status, res_status_reg;
    logic           neg_reg;
    logic [PW-1:0]  num_reg, den_reg, x_reg, y_reg, g_reg, rn_reg, rd_reg;
    logic [CW-1:0]  k_reg, cnt_reg;
    logic           m_valid_reg;
    logic [PW:0]    res_num_reg;
    logic [PW-2:0]  res_den_reg;

    logic [PW-1:0]  q_num, q_den;
    logic [PW-1:0]  rn_sh, rd_sh;
    logic           n_ge, d_ge;
    logic [PW:0]    num_signed;

    assign q_status = status_t'(pop_data[QW-1 -: 2]);
    assign q_num    = pop_data[2*PW-2 -: PW];
    assign q_den    = {1'b0, pop_data[PW-2:0]};

    assign pop = (state_reg == S_IDLE) && !empty;

    assign rn_sh = {rn_reg[PW-2:0], num_reg[PW-1]};
    assign rd_sh = {rd_reg[PW-2:0], den_reg[PW-1]};
    assign n_ge  = (rn_sh >= g_reg);
    assign d_ge  = (rd_sh >= g_reg);

    assign num_signed = neg_reg ? (~{1'b0, num_reg} + 1'b1) : {1'b0, num_reg};

    assign m_tvalid = m_valid_reg;
    assign res_num  = res_num_reg;
    assign res_den  = res_den_reg;
    assign status   = res_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (!empty) begin
                        status_reg <= q_status;
                        neg_reg    <= 1'b0;
                        if (q_status != ST_OK) begin
                            num_reg   <= '0;
                            den_reg   <= '0;
                            state_reg <= S_OUT;
                        end else if (q_num == '0) begin
                            num_reg   <= '0;
                            den_reg   <= PW'(1);
                            state_reg <= S_OUT;
                        end else begin
                            neg_reg   <= pop_data[QW-3];
                            num_reg   <= q_num;
                            den_reg   <= q_den;
                            x_reg     <= q_num;
                            y_reg     <= q_den;
                            k_reg     <= '0;
                            state_reg <= S_GCD;
                        end
                    end
                end
                S_GCD: begin
                    if (x_reg == y_reg) begin
                        g_reg     <= x_reg << k_reg;
                        rn_reg    <= '0;
                        rd_reg    <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end else if (!x_reg[0] && !y_reg[0]) begin
                        x_reg <= x_reg >> 1;
                        y_reg <= y_reg >> 1;
                        k_reg <= k_reg + 1'b1;
                    end else if (!x_reg[0]) begin
                        x_reg <= x_reg >> 1;
                    end else if (!y_reg[0]) begin
                        y_reg <= y_reg >> 1;
                    end else if (x_reg > y_reg) begin
                        x_reg <= (x_reg - y_reg) >> 1;
                    end else begin
                        y_reg <= (y_reg - x_reg) >> 1;
                    end
                end
                S_DIV: begin
                    rn_reg  <= n_ge ? (rn_sh - g_reg) : rn_sh;
                    rd_reg  <= d_ge ? (rd_sh - g_reg) : rd_sh;
                    num_reg <= {num_reg[PW-2:0], n_ge};
                    den_reg <= {den_reg[PW-2:0], d_ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(PW - 1)) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        res_num_reg    <= num_signed;
                        res_den_reg    <= den_reg[PW-2:0];
                        res_status_reg <= status_reg;
                        m_valid_reg    <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_gcd_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (g_reg != '0)) else $error("zero gcd in division");
    a_ok_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_status_reg == ST_OK) |-> (res_den_reg != '0))
        else $error("zero denominator on good result");
`endif

endmodule

FILE: design/rational_arith_reduce.sv
// Rational fraction arithmetic with gcd reduction. One result per accepted
// transaction; the front end forms the cross products on one shared
// multiplier (two for multiply and divide, three plus the sum for add and
// subtract), then the back end runs the binary gcd loop and the division
// loop, the two bit-serial divisions by the gcd. Error and zero-numerator
// items skip both loops. The queue lets the front end take the next item
// while one reduces.
// Depends on rar_pkg, rar_front, rar_queue and rar_back.
module rational_arith_reduce
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // a_num, a_den, b_num, b_den
    input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]     s_tdata,
    // opcode
    input  logic [1:0]                               s_tuser,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // res_num, res_den
    output logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]     m_tdata,
    // status
    output logic [1:0]                               m_tuser
);

    localparam int W  = OPERAND_WIDTH;
    localparam int TW = ((4 * W + 7) / 8) * 8;
    localparam int QW = 4 * W + 2;

    logic          push, full, pop, empty;
    logic [QW-1:0] push_data, pop_data;
    logic [2*W:0]  res_num;
    logic [2*W-2:0] res_den;
    status_t       status;

    rar_front #(.OPERAND_WIDTH(W)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .a_num     (s_tdata[W-1:0]),
        .a_den     (s_tdata[2*W-1:W]),
        .b_num     (s_tdata[3*W-1:2*W]),
        .b_den     (s_tdata[4*W-1:3*W]),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    rar_queue #(.DATA_WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    rar_back #(.OPERAND_WIDTH(W)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (empty),
        .pop      (pop),
        .pop_data (pop_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res_num  (res_num),
        .res_den  (res_den),
        .status   (status)
    );

    assign m_tdata = TW'({res_den, res_num});
    assign m_tuser = status;

endmodule
